### design/ell_sparse_row_store_spmv_core_assert.svh
// Assertion macros for the sparse row store core checker.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef ELL_SPARSE_ROW_STORE_SPMV_CORE_ASSERT_SVH
`define ELL_SPARSE_ROW_STORE_SPMV_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ESRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esrs check failed");

// Next-cycle implication, disabled during reset.
`define ESRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esrs check failed");

`endif

### design/esrs_pkg.sv
// Shared sizes, codes, command and status structs for the sparse row store core.
// Depends on nothing; every other file but the assertion header imports it.
package esrs_pkg;

    localparam int ROWS  = 64;
    localparam int SLOTS = 8;
    localparam int COLS  = 64;

    localparam int VAL_W  = 32;
    localparam int TAG_W  = 7;
    localparam int IDX_W  = 6;
    localparam int MODE_W = 3;
    localparam int STS_W  = 2;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH     = ROWS * SLOTS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VEC_AW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CLEAR_LEN = (DEPTH > COLS) ? DEPTH : COLS;
    localparam int CLR_W     = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int RND_W     = PROD_W - FRAC_W;
    localparam int ACC_W     = RND_W + SLOT_W + 1;
    localparam int ENTRY_W   = VAL_W + TAG_W;

    localparam logic [TAG_W-1:0]         EMPTY_TAG  = TAG_W'(1) << (TAG_W - 1);
    localparam logic signed [VAL_W-1:0]  Q_ONE      = VAL_W'(1) << FRAC_W;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_SET  = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_GET  = 3'd2,
        MODE_UNIT = 3'd3,
        MODE_LOAD = 3'd4,
        MODE_PROD = 3'd5
    } mode_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NO_FREE  = 2'd1,
        STS_ZERO_SET = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ISSUE,
        ST_DRAIN,
        ST_WRITE,
        ST_UNIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              scan_rd;
        logic              commit;
        logic              unit_wr;
        logic              clear_wr;
        logic              emit;
        logic [SLOT_W-1:0] slot;
        logic [CLR_W-1:0]  clear_addr;
    } esrs_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  row_ok;
        logic  col_ok;
        logic  zero_set;
        logic  pipe_busy;
        logic  out_busy;
    } esrs_sts_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'({1'b0, {(VAL_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return {1'b0, {(VAL_W-1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(VAL_W-1){1'b0}}};
        else
            return v[VAL_W-1:0];
    endfunction

endpackage

### design/esrs_ctrl.sv
// Controller for the sparse row store core: clearing pass, item sequencing, slot counter.
// Depends on esrs_pkg; drives the datapath through esrs_cmd_t only.
module esrs_ctrl
    import esrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  esrs_sts_t sts,
    output esrs_cmd_t cmd
);

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  cnt_reg, cnt_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic               cnt_last;
    logic               clr_last;

    assign cnt_last = (cnt_reg == SLOT_W'(SLOTS - 1));
    assign clr_last = (clr_reg == CLR_W'(CLEAR_LEN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (item_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
            begin
                unique case (sts.mode) inside
                    MODE_SET, MODE_ADD, MODE_GET:
                        state_next = (sts.row_ok && sts.col_ok && !sts.zero_set)
                                     ? ST_ISSUE : ST_FINISH;
                    MODE_UNIT:
                        state_next = sts.row_ok ? ST_UNIT : ST_FINISH;
                    MODE_LOAD:
                        state_next = sts.col_ok ? ST_WRITE : ST_FINISH;
                    MODE_PROD:
                        state_next = sts.row_ok ? ST_ISSUE : ST_FINISH;
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_ISSUE:
                if (cnt_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!sts.pipe_busy)
                    state_next = (sts.mode == MODE_SET || sts.mode == MODE_ADD)
                                 ? ST_WRITE : ST_FINISH;
            ST_WRITE:
                state_next = ST_FINISH;
            ST_UNIT:
                if (cnt_last)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = '0;
        if ((state_reg == ST_ISSUE || state_reg == ST_UNIT) && !cnt_last)
            cnt_next = cnt_reg + SLOT_W'(1);
        clr_next = clr_reg;
        if (state_reg == ST_CLEAR && !clr_last)
            clr_next = clr_reg + CLR_W'(1);
    end

    always_comb
    begin
        cmd            = '0;
        cmd.slot       = cnt_reg;
        cmd.clear_addr = clr_reg;
        item_stall     = 1'b1;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear_wr = 1'b1;
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            ST_ISSUE:  cmd.scan_rd = 1'b1;
            ST_WRITE:  cmd.commit  = 1'b1;
            ST_UNIT:   cmd.unit_wr = 1'b1;
            ST_FINISH: cmd.emit    = !sts.out_busy;
            default:   cmd.accept  = 1'b0;
        endcase
    end

endmodule

### design/esrs_dp.sv
// Datapath for the sparse row store core: slot and vector memories, slot scan,
// product pipeline, accumulator and result register. Depends on esrs_pkg.
module esrs_dp
    import esrs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [MODE_W-1:0]       mode,
    input  logic [IDX_W-1:0]        row_index,
    input  logic [IDX_W-1:0]        column_index,
    input  logic signed [VAL_W-1:0] operand_value,
    input  esrs_cmd_t               cmd,
    output esrs_sts_t               sts,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [VAL_W-1:0] result_value,
    output logic [STS_W-1:0]        status
);

    // Latched item.
    logic [MODE_W-1:0]       mode_reg;
    logic [IDX_W-1:0]        row_reg;
    logic [IDX_W-1:0]        col_reg;
    logic signed [VAL_W-1:0] opv_reg;
    mode_t                   op;
    logic                    row_ok;
    logic                    col_ok;

    // Memories.
    logic [ENTRY_W-1:0]      slot_mem [DEPTH];
    logic signed [VAL_W-1:0] vec_mem [COLS];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic signed [VAL_W-1:0] vec_rd_reg;

    // Scan and product pipeline.
    logic                    rd_vld_reg;
    logic [SLOT_W-1:0]       rd_slot_reg;
    logic                    p1_vld_reg;
    logic signed [VAL_W-1:0] p1_val_reg;
    logic                    p2_vld_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    match_found_reg;
    logic [SLOT_W-1:0]       match_slot_reg;
    logic signed [VAL_W-1:0] match_val_reg;
    logic                    empty_found_reg;
    logic [SLOT_W-1:0]       empty_slot_reg;
    logic signed [VAL_W-1:0] empty_val_reg;

    // Result register.
    logic                    result_valid_reg;
    logic signed [VAL_W-1:0] result_value_reg;
    status_t                 status_reg;

    logic [TAG_W-1:0]        rd_tag;
    logic signed [VAL_W-1:0] rd_val;
    logic                    rd_empty;
    logic                    rd_in_range;
    logic                    scan_slot;
    logic                    p1_en;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd_full;
    logic signed [RND_W-1:0]  rnd;
    logic [ADDR_W-1:0]       base_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    found;
    logic [SLOT_W-1:0]       chosen_slot;
    logic signed [VAL_W-1:0] chosen_val;
    logic signed [VAL_W-1:0] new_val;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]      wr_data;
    logic                    vec_wr_en;
    logic [VEC_AW-1:0]       vec_wr_addr;
    logic signed [VAL_W-1:0] vec_wr_data;
    logic signed [VAL_W-1:0] res_value;
    status_t                 res_status;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            row_reg  <= row_index;
            col_reg  <= column_index;
            opv_reg  <= operand_value;
        end
    end

    assign op     = mode_t'(mode_reg);
    assign row_ok = (32'(row_reg) < ROWS);
    assign col_ok = (32'(col_reg) < COLS);

    assign sts.mode      = op;
    assign sts.row_ok    = row_ok;
    assign sts.col_ok    = col_ok;
    assign sts.zero_set  = (op == MODE_SET) && (opv_reg == '0);
    assign sts.pipe_busy = rd_vld_reg || p1_vld_reg || p2_vld_reg;
    assign sts.out_busy  = result_valid_reg && result_stall;

    assign base_addr = ADDR_W'(32'(row_reg) * SLOTS);
    assign rd_addr   = base_addr + ADDR_W'(cmd.slot);

    assign rd_tag      = rd_data_reg[TAG_W-1:0];
    assign rd_val      = rd_data_reg[ENTRY_W-1:TAG_W];
    assign rd_empty    = rd_tag[TAG_W-1];
    assign rd_in_range = !rd_empty && (32'(rd_tag) < COLS);
    assign scan_slot   = rd_vld_reg && (op == MODE_SET || op == MODE_ADD || op == MODE_GET);
    assign p1_en       = rd_vld_reg && (op == MODE_PROD) && rd_in_range;

    // A matching slot wins; otherwise the last empty slot seen in the row.
    assign found       = match_found_reg || empty_found_reg;
    assign chosen_slot = match_found_reg ? match_slot_reg : empty_slot_reg;
    assign chosen_val  = match_found_reg ? match_val_reg : empty_val_reg;
    assign new_val     = (op == MODE_SET) ? opv_reg
                         : sat_val(ACC_W'(chosen_val) + ACC_W'(opv_reg));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = base_addr + ADDR_W'(cmd.slot);
        wr_data = {{VAL_W{1'b0}}, EMPTY_TAG};
        if (cmd.clear_wr)
        begin
            wr_en   = (32'(cmd.clear_addr) < DEPTH);
            wr_addr = ADDR_W'(cmd.clear_addr);
        end
        else if (cmd.unit_wr)
        begin
            wr_en = 1'b1;
            if (cmd.slot == '0)
                wr_data = {Q_ONE, TAG_W'(row_reg)};
        end
        else if (cmd.commit && (op == MODE_SET || op == MODE_ADD) && found)
        begin
            wr_en   = 1'b1;
            wr_addr = base_addr + ADDR_W'(chosen_slot);
            wr_data = {new_val, TAG_W'(col_reg)};
        end
    end

    always_comb
    begin
        vec_wr_en   = 1'b0;
        vec_wr_addr = VEC_AW'(col_reg);
        vec_wr_data = opv_reg;
        if (cmd.clear_wr)
        begin
            vec_wr_en   = (32'(cmd.clear_addr) < COLS);
            vec_wr_addr = VEC_AW'(cmd.clear_addr);
            vec_wr_data = '0;
        end
        else if (cmd.commit && op == MODE_LOAD && col_ok)
            vec_wr_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        if (cmd.scan_rd)
            rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vec_wr_en)
            vec_mem[vec_wr_addr] <= vec_wr_data;
        if (p1_en)
            vec_rd_reg <= vec_mem[VEC_AW'(rd_tag)];
    end

    assign prod     = PROD_W'(p1_val_reg) * PROD_W'(vec_rd_reg);
    assign rnd_full = p2_reg + ROUND_HALF;
    assign rnd      = rnd_full[PROD_W-1:FRAC_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg      <= 1'b0;
            p1_vld_reg      <= 1'b0;
            p2_vld_reg      <= 1'b0;
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            p1_vld_reg <= p1_en;
            p2_vld_reg <= p1_vld_reg;
            if (cmd.accept)
            begin
                match_found_reg <= 1'b0;
                empty_found_reg <= 1'b0;
            end
            else if (scan_slot)
            begin
                if (rd_empty)
                    empty_found_reg <= 1'b1;
                else if (rd_tag == TAG_W'(col_reg))
                    match_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
            rd_slot_reg <= cmd.slot;
        if (p1_en)
            p1_val_reg <= rd_val;
        if (p1_vld_reg)
            p2_reg <= prod;
        if (cmd.accept)
            acc_reg <= '0;
        else if (p2_vld_reg)
            acc_reg <= acc_reg + ACC_W'(rnd);
        if (scan_slot)
        begin
            if (rd_empty)
            begin
                empty_slot_reg <= rd_slot_reg;
                empty_val_reg  <= rd_val;
            end
            else if (rd_tag == TAG_W'(col_reg) && !match_found_reg)
            begin
                match_slot_reg <= rd_slot_reg;
                match_val_reg  <= rd_val;
            end
        end
    end

    always_comb
    begin
        res_value  = '0;
        res_status = STS_OK;
        case (op) inside
            MODE_SET, MODE_ADD:
                if (row_ok && col_ok)
                begin
                    if (sts.zero_set)
                        res_status = STS_ZERO_SET;
                    else if (!found)
                        res_status = STS_NO_FREE;
                end
            MODE_GET:
                if (row_ok && col_ok && match_found_reg)
                    res_value = match_val_reg;
            MODE_PROD:
                if (row_ok)
                    res_value = sat_val(acc_reg);
            default:
                res_value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.emit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_value_reg <= res_value;
            status_reg       <= res_status;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

endmodule

### design/ell_sparse_row_store_spmv_core.sv
// Top level of the fixed-slot sparse row store with row dot product (Q16.16).
// Depends on esrs_pkg, esrs_ctrl and esrs_dp.
//
//   channel | valid        | stall        | words
//   --------+--------------+--------------+---------------------------------------------
//   item    | item_valid   | item_stall   | mode, row_index, column_index, operand_value
//   result  | result_valid | result_stall | result_value, status
//
// After decode, set and add scan the row, drain and write; get and row product scan and drain;
// unit row writes the row; vector load writes the vector; a zero set goes straight to finish.
// The slot memory has one read port and the scan reads one slot a cycle.
// After reset a clearing pass that empties every slot and zeroes the vector holds item_stall high.
// One item is in work at a time; the next word is taken in the cycle after the result is loaded,
// while it waits in the output register, and a stalled result holds the final step only.
module ell_sparse_row_store_spmv_core
    import esrs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [MODE_W-1:0]       mode,
    input  logic [IDX_W-1:0]        row_index,
    input  logic [IDX_W-1:0]        column_index,
    input  logic signed [VAL_W-1:0] operand_value,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [VAL_W-1:0] result_value,
    output logic [STS_W-1:0]        status
);

    esrs_cmd_t cmd;
    esrs_sts_t sts;

    esrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    esrs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .row_index     (row_index),
        .column_index  (column_index),
        .operand_value (operand_value),
        .cmd           (cmd),
        .sts           (sts),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_value  (result_value),
        .status        (status)
    );

endmodule

### design/esrs_checker.sv
// Port-level checks for the sparse row store core, bound to the top level.
// Depends on esrs_pkg and ell_sparse_row_store_spmv_core_assert.svh.
`include "ell_sparse_row_store_spmv_core_assert.svh"

module esrs_checker
    import esrs_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_stall,
    input logic                    result_valid,
    input logic                    result_stall,
    input logic signed [VAL_W-1:0] result_value,
    input logic [STS_W-1:0]        status
);

    logic item_taken;
    logic result_held;

    assign item_taken  = item_valid && !item_stall;
    assign result_held = result_valid && result_stall;

    // Only one item is in work, so a taken word closes the input for a while.
    `ESRS_ASSERT_NEXT(a_busy_after_take, item_taken, item_stall)
    // Only a read or a product carries a value; failed writes report zero.
    `ESRS_ASSERT_NOW(a_status_zero_value, result_valid && status != STS_OK, result_value == '0)
    `ESRS_ASSERT_NOW(a_status_code, result_valid, status <= STS_ZERO_SET)
    `ESRS_ASSERT_NEXT(a_result_hold, result_held, result_valid)
    `ESRS_ASSERT_NEXT(a_result_stable, result_held, $stable(result_value) && $stable(status))

endmodule

bind ell_sparse_row_store_spmv_core esrs_checker u_esrs_checker (.*);

### sim/tb_top.sv
// Self-checking bench for ell_sparse_row_store_spmv_core: set, add, get, unit row,
// vector load and row dot product, predicted in Q16.16 and checked word by word.
// Depends on esrs_pkg and the core RTL only.
module tb_top;
    import esrs_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_ITEM = 500;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

    // Predicts every result of the row store and checks the results in order.
    class spmv_scoreboard;
        typedef struct {
            logic signed [VAL_W-1:0] value;
            status_t                 sts;
        } reply_t;

        logic signed [VAL_W-1:0] entry_value [DEPTH];
        logic [TAG_W-1:0]        entry_tag [DEPTH];
        logic signed [VAL_W-1:0] vec_elem [COLS];
        reply_t                  replies_due [$];
        int                      mode_seen [8];
        int                      errors;
        int                      checked;
        int                      full_row_hits;
        int                      zero_set_hits;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_value[i] = '0;
                entry_tag[i]   = EMPTY_TAG;
            end
            for (int i = 0; i < COLS; i++)
                vec_elem[i] = '0;
            foreach (mode_seen[i])
                mode_seen[i] = 0;
            errors        = 0;
            checked       = 0;
            full_row_hits = 0;
            zero_set_hits = 0;
        endfunction

        function logic signed [VAL_W-1:0] clamp32(longint v);
            if (v > longint'(32'sh7fff_ffff))
                return 32'sh7fff_ffff;
            if (v < -longint'(32'sh7fff_ffff) - 1)
                return 32'sh8000_0000;
            return v[VAL_W-1:0];
        endfunction

        // Matching slot of the row, else the highest empty one, else -1.
        function int locate_slot(int base, logic [IDX_W-1:0] col);
            int free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (entry_tag[base + i][TAG_W-1])
                    free_slot = i;
                else if (entry_tag[base + i] == {1'b0, col})
                    return i;
            end
            return free_slot;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        function void note_item(mode_t m, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic signed [VAL_W-1:0] v);
            reply_t rep;
            int     base;
            int     s;
            longint acc;
            rep.value = '0;
            rep.sts   = STS_OK;
            base      = int'(row) * SLOTS;
            mode_seen[int'(m)]++;
            case (m)
                MODE_SET, MODE_ADD:
                begin
                    if (m == MODE_SET && v == 0)
                        rep.sts = STS_ZERO_SET;
                    else
                    begin
                        s = locate_slot(base, col);
                        if (s < 0)
                            rep.sts = STS_NO_FREE;
                        else
                        begin
                            if (m == MODE_SET)
                                entry_value[base + s] = v;
                            else
                                entry_value[base + s] =
                                    clamp32(longint'(entry_value[base + s]) + longint'(v));
                            entry_tag[base + s] = {1'b0, col};
                        end
                    end
                end
                MODE_GET:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!entry_tag[base + i][TAG_W-1] && entry_tag[base + i] == {1'b0, col})
                        begin
                            rep.value = entry_value[base + i];
                            break;
                        end
                    end
                end
                MODE_UNIT:
                begin
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        entry_value[base + i] = '0;
                        entry_tag[base + i]   = EMPTY_TAG;
                    end
                    entry_value[base] = Q_ONE;
                    entry_tag[base]   = {1'b0, row};
                end
                MODE_LOAD:
                    vec_elem[col] = v;
                MODE_PROD:
                begin
                    acc = 0;
                    // Empty slots take no part; each product rounds half up to Q16.16.
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!entry_tag[base + i][TAG_W-1])
                            acc += (longint'(entry_value[base + i]) *
                                    longint'(vec_elem[entry_tag[base + i][IDX_W-1:0]]) +
                                    64'sd32768) >>> FRAC_W;
                    end
                    rep.value = clamp32(acc);
                end
                default:
                    ;
            endcase
            if (rep.sts == STS_NO_FREE)
                full_row_hits++;
            if (rep.sts == STS_ZERO_SET)
                zero_set_hits++;
            replies_due.push_back(rep);
        endfunction

        function void check_result(logic signed [VAL_W-1:0] value, logic [STS_W-1:0] sts);
            reply_t rep;
            if (replies_due.size() == 0)
            begin
                $error("result word with nothing outstanding: result_value %h status %0d",
                       value, sts);
                errors++;
                return;
            end
            rep = replies_due.pop_front();
            checked++;
            if (value !== rep.value)
            begin
                $error("result_value: expected %h, actual %h", rep.value, value);
                errors++;
            end
            if (sts !== rep.sts)
            begin
                $error("status: expected %0d, actual %0d", rep.sts, sts);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_stall;
    logic [MODE_W-1:0]       mode;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        column_index;
    logic signed [VAL_W-1:0] operand_value;
    logic                    result_valid;
    logic                    result_stall;
    logic signed [VAL_W-1:0] result_value;
    logic [STS_W-1:0]        status;

    spmv_scoreboard sb;
    bit             quiet;
    bit             hold_req;
    bit             hold_active;

    ell_sparse_row_store_spmv_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .row_index     (row_index),
        .column_index  (column_index),
        .operand_value (operand_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_value  (result_value),
        .status        (status)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_operand();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        if (pick < 20)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fff_ffff;
                1: return 32'sh8000_0000;
                2: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (pick < 60)
            return $urandom_range(0, 1) ? $signed(32'($urandom_range(0, 8 << 16)))
                                        : -$signed(32'($urandom_range(0, 8 << 16)));
        return $signed($urandom);
    endfunction

    task automatic send_word(input mode_t m, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v);
        int g;
        g = (!quiet && !hold_active && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_valid    <= 1'b1;
        mode          <= m;
        row_index     <= r;
        column_index  <= c;
        operand_value <= v;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // A few rows and columns most of the time, so that rows fill up and collide.
    task automatic send_random_op();
        int               pick;
        mode_t            m;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            m = MODE_SET;
        else if (pick < 45)
            m = MODE_ADD;
        else if (pick < 65)
            m = MODE_GET;
        else if (pick < 70)
            m = MODE_UNIT;
        else if (pick < 85)
            m = MODE_LOAD;
        else
            m = MODE_PROD;
        r = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 7));
        c = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 13));
        send_word(m, r, c, pick_operand());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(mode_t'(mode), row_index, column_index, operand_value);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_value, status);
    end

    initial
    begin : receiver
        hold_active = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat (gap_len()) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        sb            = new();
        quiet         = 1'b0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        item_valid    <= 1'b0;
        mode          <= MODE_SET;
        row_index     <= '0;
        column_index  <= '0;
        operand_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Saturation at both ends of the range, in add and in the dot product.
        send_word(MODE_SET, 6'd0, 6'd0, 32'sh7fff_ffff);
        send_word(MODE_ADD, 6'd0, 6'd0, 32'sd1);
        send_word(MODE_GET, 6'd0, 6'd0, 32'sd0);
        send_word(MODE_SET, 6'd0, 6'd1, 32'sd0);
        send_word(MODE_LOAD, 6'd0, 6'd0, 32'sh7fff_ffff);
        send_word(MODE_PROD, 6'd0, 6'd0, 32'sd0);
        send_word(MODE_SET, 6'd63, 6'd63, 32'sh8000_0000);
        send_word(MODE_ADD, 6'd63, 6'd63, -32'sd1);
        send_word(MODE_GET, 6'd63, 6'd63, 32'sd0);
        send_word(MODE_LOAD, 6'd0, 6'd63, 32'sh7fff_ffff);
        send_word(MODE_PROD, 6'd63, 6'd0, 32'sd0);
        // Fill one row, then ask for a ninth column.
        for (int i = 0; i < SLOTS; i++)
            send_word(MODE_SET, 6'd5, IDX_W'(10 + i), 32'(i + 1) * 32'sh0000_8000);
        send_word(MODE_SET, 6'd5, 6'd20, 32'sh0001_0000);
        send_word(MODE_ADD, 6'd5, 6'd21, 32'sh0001_0000);
        send_word(MODE_ADD, 6'd5, 6'd12, -32'sh0002_8000);
        send_word(MODE_GET, 6'd5, 6'd33, 32'sd0);
        send_word(MODE_UNIT, 6'd5, 6'd0, 32'sd0);
        send_word(MODE_GET, 6'd5, 6'd5, 32'sd0);
        send_word(MODE_LOAD, 6'd0, 6'd5, -32'sh0000_8000);
        send_word(MODE_PROD, 6'd5, 6'd0, 32'sd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 300 && n < 380);
            if (n == HOLD_AT_ITEM)
                hold_req = 1'b1;
            send_random_op();
        end
        item_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words in: set %0d, add %0d, get %0d, unit %0d, load %0d, product %0d",
                 sb.mode_seen[MODE_SET] + sb.mode_seen[MODE_ADD] + sb.mode_seen[MODE_GET] +
                 sb.mode_seen[MODE_UNIT] + sb.mode_seen[MODE_LOAD] + sb.mode_seen[MODE_PROD],
                 sb.mode_seen[MODE_SET], sb.mode_seen[MODE_ADD], sb.mode_seen[MODE_GET],
                 sb.mode_seen[MODE_UNIT], sb.mode_seen[MODE_LOAD], sb.mode_seen[MODE_PROD]);
        $display("%0d results checked, %0d full-row refusals, %0d zero sets, %0d errors",
                 sb.checked, sb.full_row_hits, sb.zero_set_hits, sb.errors);
        if (sb.errors == 0)
            $display("ell_sparse_row_store_spmv_core regression: pass");
        else
            $display("ell_sparse_row_store_spmv_core regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #2500000;
        $display("ell_sparse_row_store_spmv_core regression: fail");
        $finish;
    end

endmodule
